// ===== hdl/hpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpm_pkg
// shared types and constants of the hyphenation pattern matcher
// ----------------------------------------------------------------------------
package hpm_pkg;

    localparam logic [1:0] CMD_TRIE   = 2'd0;
    localparam logic [1:0] CMD_OP     = 2'd1;
    localparam logic [1:0] CMD_LETTER = 2'd2;

    localparam logic [8:0] BOUNDARY_CODE = 9'd127;
    localparam logic [8:0] END_CODE      = 9'd256;
    localparam logic [3:0] MIN_WORD      = 4'd5;

    typedef struct packed {
        logic [1:0]  command;
        logic [12:0] trie_index;
        logic [12:0] trie_link_value;
        logic [7:0]  trie_char_value;
        logic [7:0]  trie_op_value;
        logic [7:0]  op_index;
        logic [5:0]  op_distance;
        logic [3:0]  op_level;
        logic [7:0]  op_next;
        logic [6:0]  letter;
        logic        last_letter;
    } cmd_t;

    typedef struct packed {
        logic [5:0] position;
        logic [3:0] level;
        logic       may_break;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [12:0] link;
        logic [7:0]  chr;
        logic [7:0]  op;
    } trie_ent_t;

    typedef struct packed {
        logic [5:0] distance;
        logic [3:0] lvl;
        logic [7:0] nxt;
    } op_ent_t;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CODE  = 9'b000000010,
        ST_TRIE  = 9'b000000100,
        ST_OPCHK = 9'b000001000,
        ST_OPD   = 9'b000010000,
        ST_GAP   = 9'b000100000,
        ST_ORD   = 9'b001000000,
        ST_OVAL  = 9'b010000000,
        ST_OWAIT = 9'b100000000
    } state_t;

endpackage
`default_nettype wire

// ===== hdl/hyphenation_pattern_matcher_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hyphenation_pattern_matcher_top
// liang pattern hyphenation over a packed trie held in on-chip ram
// ----------------------------------------------------------------------------
// Trie and op loads and letters are taken one word per cycle while idle. The
// letter flagged last_letter closes the word: for words of five letters or
// more the sequencer walks the trie from every start position, each trie step
// reading the letter ram and then the trie ram, and each op in a chain reading
// the op ram and then, if its distance fits, updating the gap ram. Then it
// emits one result per letter, each from a gap ram read into the result
// register, held while res_stall is high. cmd_stall is high from the closing
// letter until the last result is taken. Tables, letters and gap levels sit
// in registered-read rams; the gap valid bits are flops, cleared at word end.
// ----------------------------------------------------------------------------
module hyphenation_pattern_matcher_top #(
    parameter int TRIE_ENTRIES = 8192,
    parameter int OP_ENTRIES   = 256,
    parameter int MAX_WORD     = 63
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  hpm_pkg::cmd_t cmd_word,
    output logic          res_valid,
    input  logic          res_stall,
    output hpm_pkg::res_t res_word
);

    import hpm_pkg::*;

    localparam int TAW       = $clog2(TRIE_ENTRIES);
    localparam int OAW       = $clog2(OP_ENTRIES);
    localparam int CW        = $clog2(MAX_WORD + 1);
    localparam int LW        = $clog2(MAX_WORD + 3);
    localparam int GAP_DEPTH = MAX_WORD + 2;
    localparam int GAW       = $clog2(GAP_DEPTH);
    localparam int SW        = $clog2(OP_ENTRIES) + 1;

    // sequencer state
    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;   // letters in the word, n
    logic [CW-1:0]        j_reg, j_next;           // walk start, then result index
    logic [LW-1:0]        l_reg, l_next;           // letter slot under the walk
    logic                 first_reg, first_next;   // first trie step of a walk
    logic [SW-1:0]        steps_reg, steps_next;   // op chain length guard
    logic [GAP_DEPTH-1:0] gap_vld_reg, gap_vld_next;
    logic                 res_valid_reg, res_valid_next;

    // working payload
    logic [8:0]           code_reg, code_next;
    logic [12:0]          link_reg, link_next;
    logic [7:0]           v_reg, v_next;
    logic [GAW-1:0]       g_reg, g_next;
    logic [3:0]           lvl_reg, lvl_next;
    res_t                 res_word_reg, res_word_next;

    // ram ports
    logic                 trie_we;
    logic [TAW-1:0]       trie_raddr;
    logic [28:0]          trie_rdata;
    logic                 op_we;
    logic [OAW-1:0]       op_raddr;
    logic [17:0]          op_rdata;
    logic                 code_we;
    logic [6:0]           code_rdata;
    logic                 gap_we;
    logic [GAW-1:0]       gap_raddr;
    logic [3:0]           gap_wdata;
    logic [3:0]           gap_rdata;

    trie_ent_t            trie_ent;
    op_ent_t              op_ent;
    logic                 accept;
    logic [8:0]           code_now;
    logic [13:0]          z;
    logic [3:0]           gap_cur;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;
    assign trie_ent  = trie_ent_t'(trie_rdata);
    assign op_ent    = op_ent_t'(op_rdata);
    assign trie_we   = accept && (cmd_word.command == CMD_TRIE)
                       && (32'(cmd_word.trie_index) < TRIE_ENTRIES);
    assign op_we     = accept && (cmd_word.command == CMD_OP)
                       && (32'(cmd_word.op_index) < OP_ENTRIES);
    assign code_we   = accept && (cmd_word.command == CMD_LETTER)
                       && (32'(count_reg) < MAX_WORD);

    // letter code at slot l, framed by boundaries and the terminator
    always_comb
    begin
        if (l_reg == '0)
        begin
            code_now = BOUNDARY_CODE;
        end
        else if (32'(l_reg) == 32'(count_reg) + 1)
        begin
            code_now = BOUNDARY_CODE;
        end
        else if (32'(l_reg) == 32'(count_reg) + 2)
        begin
            code_now = END_CODE;
        end
        else
        begin
            code_now = {2'b00, code_rdata};
        end
    end

    // next trie slot: the letter itself on the first step, else link plus letter
    assign z = first_reg ? {5'd0, code_now} : ({1'b0, link_reg} + {5'd0, code_now});
    assign gap_cur = gap_vld_reg[g_reg] ? gap_rdata : 4'd0;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        j_next         = j_reg;
        l_next         = l_reg;
        first_next     = first_reg;
        steps_next     = steps_reg;
        gap_vld_next   = gap_vld_reg;
        res_valid_next = res_valid_reg;
        code_next      = code_reg;
        link_next      = link_reg;
        v_next         = v_reg;
        g_next         = g_reg;
        lvl_next       = lvl_reg;
        res_word_next  = res_word_reg;
        trie_raddr     = TAW'(z);
        op_raddr       = OAW'(v_reg);
        gap_raddr      = g_reg;
        gap_we         = 1'b0;
        gap_wdata      = lvl_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd_word.command == CMD_LETTER))
                begin
                    if (code_we)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (cmd_word.last_letter)
                    begin
                        if (32'(count_next) >= 32'(MIN_WORD))
                        begin
                            j_next     = '0;
                            l_next     = '0;
                            first_next = 1'b1;
                            state_next = ST_CODE;
                        end
                        else
                        begin
                            j_next     = CW'(1);
                            state_next = ST_ORD;
                        end
                    end
                end
            end

            ST_CODE:
            begin
                // letter code is ready, fetch the trie slot
                code_next = code_now;
                if (32'(z) < TRIE_ENTRIES)
                begin
                    state_next = ST_TRIE;
                end
                else if (32'(j_reg) + 3 <= 32'(count_reg))
                begin
                    j_next     = j_reg + 1'b1;
                    l_next     = LW'(j_reg) + 1'b1;
                    first_next = 1'b1;
                    state_next = ST_CODE;
                end
                else
                begin
                    j_next     = CW'(1);
                    state_next = ST_ORD;
                end
            end

            ST_TRIE:
            begin
                if ({1'b0, trie_ent.chr} == code_reg)
                begin
                    link_next = trie_ent.link;
                    if (trie_ent.op != 8'd0)
                    begin
                        v_next     = trie_ent.op;
                        steps_next = '0;
                        state_next = ST_OPCHK;
                    end
                    else
                    begin
                        l_next     = l_reg + 1'b1;
                        first_next = 1'b0;
                        state_next = ST_CODE;
                    end
                end
                else if (32'(j_reg) + 3 <= 32'(count_reg))
                begin
                    j_next     = j_reg + 1'b1;
                    l_next     = LW'(j_reg) + 1'b1;
                    first_next = 1'b1;
                    state_next = ST_CODE;
                end
                else
                begin
                    j_next     = CW'(1);
                    state_next = ST_ORD;
                end
            end

            ST_OPCHK:
            begin
                if ((v_reg != 8'd0) && (32'(v_reg) < OP_ENTRIES)
                    && (32'(steps_reg) < OP_ENTRIES))
                begin
                    state_next = ST_OPD;
                end
                else
                begin
                    l_next     = l_reg + 1'b1;
                    first_next = 1'b0;
                    state_next = ST_CODE;
                end
            end

            ST_OPD:
            begin
                v_next     = op_ent.nxt;
                steps_next = steps_reg + 1'b1;
                if (32'(op_ent.distance) <= 32'(l_reg))
                begin
                    g_next     = GAW'(l_reg - LW'(op_ent.distance));
                    gap_raddr  = g_next;
                    lvl_next   = op_ent.lvl;
                    state_next = ST_GAP;
                end
                else
                begin
                    state_next = ST_OPCHK;
                end
            end

            ST_GAP:
            begin
                if (lvl_reg > gap_cur)
                begin
                    gap_we              = 1'b1;
                    gap_vld_next[g_reg] = 1'b1;
                end
                state_next = ST_OPCHK;
            end

            ST_ORD:
            begin
                gap_raddr  = GAW'(j_reg);
                state_next = ST_OVAL;
            end

            ST_OVAL:
            begin
                // edge gaps and short words carry no level
                res_word_next.position = 6'(j_reg);
                if ((32'(count_reg) < 32'(MIN_WORD)) || (j_reg == CW'(1))
                    || (32'(j_reg) + 2 >= 32'(count_reg)))
                begin
                    res_word_next.level = 4'd0;
                end
                else
                begin
                    res_word_next.level = gap_vld_reg[GAW'(j_reg)] ? gap_rdata : 4'd0;
                end
                res_word_next.may_break = res_word_next.level[0];
                res_word_next.last      = (j_reg == count_reg);
                res_valid_next          = 1'b1;
                state_next              = ST_OWAIT;
            end

            ST_OWAIT:
            begin
                if (!res_stall)
                begin
                    res_valid_next = 1'b0;
                    if (j_reg == count_reg)
                    begin
                        count_next   = '0;
                        gap_vld_next = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_ORD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            j_reg         <= '0;
            l_reg         <= '0;
            first_reg     <= 1'b0;
            steps_reg     <= '0;
            gap_vld_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            j_reg         <= j_next;
            l_reg         <= l_next;
            first_reg     <= first_next;
            steps_reg     <= steps_next;
            gap_vld_reg   <= gap_vld_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        link_reg     <= link_next;
        v_reg        <= v_next;
        g_reg        <= g_next;
        lvl_reg      <= lvl_next;
        res_word_reg <= res_word_next;
    end

    // packed trie: link, char, op
    hpm_ram #(
        .WIDTH (29),
        .DEPTH (TRIE_ENTRIES)
    ) u_trie_ram (
        .clk     (clk),
        .wr_en   (trie_we),
        .wr_addr (TAW'(cmd_word.trie_index)),
        .wr_data ({cmd_word.trie_link_value, cmd_word.trie_char_value,
                   cmd_word.trie_op_value}),
        .rd_addr (trie_raddr),
        .rd_data (trie_rdata)
    );

    // op table: distance, level, next
    hpm_ram #(
        .WIDTH (18),
        .DEPTH (OP_ENTRIES)
    ) u_op_ram (
        .clk     (clk),
        .wr_en   (op_we),
        .wr_addr (OAW'(cmd_word.op_index)),
        .wr_data ({cmd_word.op_distance, cmd_word.op_level, cmd_word.op_next}),
        .rd_addr (op_raddr),
        .rd_data (op_rdata)
    );

    // word letters at slots 1..n, addressed by l_next so each is ready with l_reg
    hpm_ram #(
        .WIDTH (7),
        .DEPTH (MAX_WORD + 1)
    ) u_code_ram (
        .clk     (clk),
        .wr_en   (code_we),
        .wr_addr (count_reg + 1'b1),
        .wr_data (cmd_word.letter),
        .rd_addr (l_next[CW-1:0]),
        .rd_data (code_rdata)
    );

    // gap levels, qualified by gap_vld_reg
    hpm_ram #(
        .WIDTH (4),
        .DEPTH (GAP_DEPTH)
    ) u_gap_ram (
        .clk     (clk),
        .wr_en   (gap_we),
        .wr_addr (g_reg),
        .wr_data (gap_wdata),
        .rd_addr (gap_raddr),
        .rd_data (gap_rdata)
    );

`ifndef ASSERT_OFF
    // a shown result always names a letter of the current word
    a_res_position: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_word.position != 6'd0)
                      && (32'(res_word.position) <= 32'(count_reg)))
        else $error("result position outside the word");

    // taking the final result leaves the word state cleared
    a_word_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && res_word.last)
        |=> (count_reg == '0) && (gap_vld_reg == '0))
        else $error("word state not cleared after final result");

    // gap writes only raise a level, and only from the update step
    a_gap_write: assert property (@(posedge clk) disable iff (!rst_n)
        gap_we |-> (gap_wdata != 4'd0) && (state_reg == ST_GAP))
        else $error("unexpected gap level write");
`endif

endmodule
`default_nettype wire

// ===== hdl/hpm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module hpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire
